// File: rtl/lstk_pkg.sv
// ----------------------------------------------------------------------------
// lstk_pkg
// Shared constants, codes and types of the bounded LIFO stack with reverse.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lstk_pkg;

	localparam int DEPTH       = 128;
	localparam int DATA_W      = 32;
	localparam int ADDR_W      = $clog2(DEPTH);
	localparam int CNT_W       = $clog2(DEPTH + 1);
	localparam int COUNT_OUT_W = 8;

	typedef enum logic [1:0] {
		ACT_PUSH    = 2'd0,
		ACT_POP     = 2'd1,
		ACT_BOTTOM  = 2'd2,
		ACT_REVERSE = 2'd3
	} lstk_action_t;

	typedef enum logic [1:0] {
		STAT_OK  = 2'd0,
		STAT_OVF = 2'd1,
		STAT_UNF = 2'd2
	} lstk_status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_POP_RD,
		ST_SH_RD,
		ST_SH_WR,
		ST_BOT_WR,
		ST_RV_RD_LO,
		ST_RV_RD_HI,
		ST_RV_WR_LO,
		ST_RV_WR_HI,
		ST_DONE
	} lstk_state_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [DATA_W-1:0] wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} lstk_mem_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] popped_value;
		lstk_status_t             status;
		logic [COUNT_OUT_W-1:0]   entry_count;
		logic                     is_empty;
		logic                     is_full;
	} lstk_res_t;

endpackage

// File: rtl/lstk_if.sv
// ----------------------------------------------------------------------------
// lstk_if
// Valid/ready channels of the stack: request channel and response channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lstk_req_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic signed [31:0] value;

	modport source (output valid, output action, output value, input ready);
	modport sink (input valid, input action, input value, output ready);
endinterface

interface lstk_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] popped_value;
	logic [1:0]         status;
	logic [7:0]         entry_count;
	logic               is_empty;
	logic               is_full;

	modport source (output valid, output popped_value, output status, output entry_count,
		output is_empty, output is_full, input ready);
	modport sink (input valid, input popped_value, input status, input entry_count,
		input is_empty, input is_full, output ready);
endinterface

// File: rtl/lstk_ram.sv
// ----------------------------------------------------------------------------
// lstk_ram
// Simple dual-port synchronous RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lstk_ram #(
	parameter int Depth = 128,
	parameter int Width = 32,
	localparam int AddrW = $clog2(Depth)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic             re,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/lstk_ctrl.sv
// ----------------------------------------------------------------------------
// lstk_ctrl
// Sequencer of the stack: fill count, memory accesses and per-action result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lstk_ctrl import lstk_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	lstk_req_if.sink          req,
	output lstk_mem_req_t     mem_req,
	input  logic [DATA_W-1:0] mem_rdata,
	output logic              res_valid,
	output lstk_res_t         res,
	input  logic              res_ready
);

	lstk_state_t              state_q, state_d;
	logic [CNT_W-1:0]         count_q, count_d;
	logic [ADDR_W-1:0]        idx_q, idx_d;
	logic [ADDR_W-1:0]        lo_q, lo_d;
	logic [ADDR_W-1:0]        hi_q, hi_d;
	logic [DATA_W-1:0]        val_q, val_d;
	logic [DATA_W-1:0]        tmp_q, tmp_d;
	logic signed [DATA_W-1:0] popped_q, popped_d;
	lstk_status_t             status_q, status_d;
	logic                     is_full;
	logic                     is_empty;

	assign is_full  = (count_q == CNT_W'(DEPTH));
	assign is_empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_d;
		lo_q     <= lo_d;
		hi_q     <= hi_d;
		val_q    <= val_d;
		tmp_q    <= tmp_d;
		popped_q <= popped_d;
		status_q <= status_d;
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		lo_d      = lo_q;
		hi_d      = hi_q;
		val_d     = val_q;
		tmp_d     = tmp_q;
		popped_d  = popped_q;
		status_d  = status_q;
		mem_req   = '0;
		req.ready = 1'b0;
		res_valid = 1'b0;

		case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (req.valid) begin
					popped_d = '0;
					status_d = STAT_OK;
					val_d    = req.value;
					state_d  = ST_DONE;
					case (lstk_action_t'(req.action))
						ACT_PUSH: begin
							if (is_full) begin
								status_d = STAT_OVF;
							end else begin
								mem_req.we    = 1'b1;
								mem_req.waddr = count_q[ADDR_W-1:0];
								mem_req.wdata = req.value;
								count_d       = count_q + CNT_W'(1);
							end
						end
						ACT_POP: begin
							if (is_empty) begin
								popped_d = '1;
								status_d = STAT_UNF;
							end else begin
								mem_req.re    = 1'b1;
								mem_req.raddr = ADDR_W'(count_q - CNT_W'(1));
								count_d       = count_q - CNT_W'(1);
								state_d       = ST_POP_RD;
							end
						end
						ACT_BOTTOM: begin
							if (is_full) begin
								status_d = STAT_OVF;
							end else if (is_empty) begin
								state_d = ST_BOT_WR;
							end else begin
								idx_d   = ADDR_W'(count_q - CNT_W'(1));
								state_d = ST_SH_RD;
							end
						end
						ACT_REVERSE: begin
							if (count_q >= CNT_W'(2)) begin
								lo_d    = '0;
								hi_d    = ADDR_W'(count_q - CNT_W'(1));
								state_d = ST_RV_RD_LO;
							end
						end
						default: begin
							state_d = ST_DONE;
						end
					endcase
				end
			end
			ST_POP_RD: begin
				popped_d = $signed(mem_rdata);
				state_d  = ST_DONE;
			end
			// move entries up one slot, top first
			ST_SH_RD: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = idx_q;
				state_d       = ST_SH_WR;
			end
			ST_SH_WR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = idx_q + ADDR_W'(1);
				mem_req.wdata = mem_rdata;
				if (idx_q == '0) begin
					state_d = ST_BOT_WR;
				end else begin
					idx_d   = idx_q - ADDR_W'(1);
					state_d = ST_SH_RD;
				end
			end
			ST_BOT_WR: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = '0;
				mem_req.wdata = val_q;
				count_d       = count_q + CNT_W'(1);
				state_d       = ST_DONE;
			end
			// swap one pair of entries from the outside in
			ST_RV_RD_LO: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = lo_q;
				state_d       = ST_RV_RD_HI;
			end
			ST_RV_RD_HI: begin
				mem_req.re    = 1'b1;
				mem_req.raddr = hi_q;
				tmp_d         = mem_rdata;
				state_d       = ST_RV_WR_LO;
			end
			ST_RV_WR_LO: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = lo_q;
				mem_req.wdata = mem_rdata;
				state_d       = ST_RV_WR_HI;
			end
			ST_RV_WR_HI: begin
				mem_req.we    = 1'b1;
				mem_req.waddr = hi_q;
				mem_req.wdata = tmp_q;
				lo_d          = lo_q + ADDR_W'(1);
				hi_d          = hi_q - ADDR_W'(1);
				if (({1'b0, hi_q} - {1'b0, lo_q}) > (ADDR_W + 1)'(2)) begin
					state_d = ST_RV_RD_LO;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res.popped_value = popped_q;
	assign res.status       = status_q;
	assign res.entry_count  = COUNT_OUT_W'(count_q);
	assign res.is_empty     = is_empty;
	assign res.is_full      = is_full;

endmodule

// File: rtl/lifo_stack_with_reverse.sv
// ----------------------------------------------------------------------------
// lifo_stack_with_reverse
// After accept, push, refused requests and reverse of under two entries go to
// ST_DONE; pop reads via ST_POP_RD; insert at bottom shifts the n entries up
// (ST_SH_RD, ST_SH_WR), then writes slot 0 (ST_BOT_WR); reverse swaps pairs
// via the RV read and write states. One request in the sequencer at a time:
// the next is accepted once the last response has entered the output register.
// Reset clears the fill count and the sequencer; RAM contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lifo_stack_with_reverse import lstk_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	lstk_req_if.sink   req,
	lstk_rsp_if.source rsp
);

	lstk_mem_req_t     mem_req;
	logic [DATA_W-1:0] mem_rdata;
	logic              res_valid;
	logic              res_ready;
	lstk_res_t         res;
	logic              rsp_valid_q;
	lstk_res_t         rsp_q;

	lstk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (res_ready)
	);

	lstk_ram #(
		.Depth (DEPTH),
		.Width (DATA_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

	// output register: free when empty or draining this cycle
	assign res_ready = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_ready) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid        = rsp_valid_q;
	assign rsp.popped_value = rsp_q.popped_value;
	assign rsp.status       = rsp_q.status;
	assign rsp.entry_count  = rsp_q.entry_count;
	assign rsp.is_empty     = rsp_q.is_empty;
	assign rsp.is_full      = rsp_q.is_full;

endmodule

// File: rtl/lstk_checker.sv
// ----------------------------------------------------------------------------
// lstk_checker
// Port-level checks on the response channel of the stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lstk_checker import lstk_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input logic signed [31:0] popped_value,
	input logic [1:0]         status,
	input logic [7:0]         entry_count,
	input logic               is_empty,
	input logic               is_full
);

	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && is_empty |-> entry_count == '0 && !is_full)
		else $error("empty response with nonzero count or full flag");

	a_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STAT_UNF |-> popped_value == -32'sd1 && is_empty)
		else $error("underflow response without -1 or with entries left");

	a_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STAT_OVF |-> is_full && popped_value == '0)
		else $error("overflow response on a stack that is not full");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(popped_value) && $stable(status)
			&& $stable(entry_count))
		else $error("stalled response changed");

endmodule

bind lifo_stack_with_reverse lstk_checker u_lstk_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.popped_value (rsp.popped_value),
	.status       (rsp.status),
	.entry_count  (rsp.entry_count),
	.is_empty     (rsp.is_empty),
	.is_full      (rsp.is_full)
);
